FILE: src/hough_circle_vote_accumulator_defines.svh
// Assertion macros used by the top-level file to check its own logic.
`ifndef HOUGH_CIRCLE_VOTE_ACCUMULATOR_DEFINES_SVH
`define HOUGH_CIRCLE_VOTE_ACCUMULATOR_DEFINES_SVH

`ifndef ASSERT_OFF
`define HCA_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define HCA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define HCA_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg)
`define HCA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

FILE: src/hca_pkg.sv
`timescale 1ns / 1ps

package hca_pkg;

   localparam int IMAGE_ROWS_DEF = 240;
   localparam int IMAGE_COLS_DEF = 320;
   localparam int NUM_RADII_DEF  = 50;

   localparam int CMD_W    = 2;
   localparam int ROW_W    = 8;
   localparam int COL_W    = 9;
   localparam int RIDX_W   = 6;
   localparam int PIX_W    = 8;
   localparam int RADIUS_W = 8;
   localparam int COUNT_W  = 3;
   localparam int CAST_W   = 8;
   localparam int REQ_W    = 32;
   localparam int RSP_W    = 16;
   localparam int COORD_W  = 14;
   localparam int EPOCH_W  = 4;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [RADIUS_W-1:0] MIN_RADIUS_RST     = 8'd10;
   localparam logic [PIX_W-1:0]    EDGE_VALUE_RST     = 8'd255;
   localparam logic [COUNT_W-1:0]  VOTE_THRESHOLD_RST = 3'd1;
   localparam logic [COUNT_W-1:0]  COUNT_MAX          = 3'd4;

   typedef enum logic [CMD_W-1:0] {
      CMD_VOTE  = 2'd0,
      CMD_QUERY = 2'd1,
      CMD_CLEAR = 2'd2
   } hca_cmd_type;

   typedef enum logic [1:0] {
      REG_MIN_RADIUS     = 2'd0,
      REG_EDGE_VALUE     = 2'd1,
      REG_VOTE_THRESHOLD = 2'd2
   } hca_reg_type;

   typedef enum logic [1:0] {
      DIR_LEFT  = 2'd0,
      DIR_UP    = 2'd1,
      DIR_RIGHT = 2'd2,
      DIR_DOWN  = 2'd3
   } hca_dir_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_ISSUE,
      ST_DRAIN,
      ST_WIPE,
      ST_FINISH
   } hca_state_type;

   typedef struct packed {
      logic              valid;
      logic              query;
      logic              last;
      logic              k_ok;
      hca_dir_type       dir;
      logic [ROW_W-1:0]  row;
      logic [COL_W-1:0]  col;
   } hca_op_type;

   typedef struct packed {
      logic valid;
      logic query;
      logic last;
      logic hit;
   } hca_flags_type;

   function automatic int idx_width(input longint unsigned n);
      int w;
      w = (n > 1) ? $clog2(n) : 1;
      return w;
   endfunction

endpackage

FILE: src/hough_circle_vote_accumulator.sv
`timescale 1ns / 1ps
`include "hough_circle_vote_accumulator_defines.svh"

// Hough circle vote accumulator. Each word on the request stream is a pixel vote, a cell query,
// a clear or an unused command, and each produces exactly one response word. An edge pixel
// issues four votes per radius, one per cycle, into a single memory of 3-bit counters that
// saturate at 4, through a pipelined address generator and a read-modify-write stage with
// forwarding. A clear advances a 4-bit epoch kept in every memory word; every sixteenth clear
// also rewrites the whole memory. After reset the same whole-memory pass runs once before the
// first request word is taken; configuration writes are accepted throughout. Requests are
// taken only while the block is idle, whilst a finished response may still be waiting in its
// output register.
module hough_circle_vote_accumulator #(
   parameter int IMAGE_ROWS = hca_pkg::IMAGE_ROWS_DEF,
   parameter int IMAGE_COLS = hca_pkg::IMAGE_COLS_DEF,
   parameter int NUM_RADII  = hca_pkg::NUM_RADII_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // Fields from bit 0: row[7:0], col[16:8], radius_index[22:17], pixel[30:23].
   input  logic [hca_pkg::REQ_W-1:0]          req_tdata,
   // Field from bit 0: command[1:0].
   input  logic [hca_pkg::CMD_W-1:0]          req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // Fields from bit 0: vote_count[2:0], is_circle[3], votes_cast[11:4].
   output logic [hca_pkg::RSP_W-1:0]          rsp_tdata,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [hca_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [hca_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [hca_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                               csr_pready
);

   localparam longint unsigned CELLS =
      longint'(IMAGE_ROWS) * longint'(IMAGE_COLS) * longint'(NUM_RADII);
   localparam int K_W    = hca_pkg::idx_width(NUM_RADII);
   localparam int ADDR_W = hca_pkg::idx_width(CELLS);

   logic [hca_pkg::RADIUS_W-1:0] min_radius_in, min_radius_ff;
   logic [hca_pkg::PIX_W-1:0]    edge_value_in, edge_value_ff;
   logic [hca_pkg::COUNT_W-1:0]  vote_threshold_in, vote_threshold_ff;
   logic                         csr_wr;
   hca_pkg::hca_reg_type         csr_reg;

   hca_pkg::hca_op_type          op;
   logic [K_W-1:0]               op_k;
   hca_pkg::hca_flags_type       addr_flags;
   logic [ADDR_W-1:0]            addr;
   hca_pkg::hca_flags_type       retire_flags;
   logic [hca_pkg::COUNT_W-1:0]  retire_count;
   logic [hca_pkg::EPOCH_W-1:0]  epoch;
   logic                         wipe_we;
   logic [ADDR_W-1:0]            wipe_addr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_reg    = hca_pkg::hca_reg_type'(csr_paddr[3:2]);

   always_comb begin
      min_radius_in     = min_radius_ff;
      edge_value_in     = edge_value_ff;
      vote_threshold_in = vote_threshold_ff;
      csr_prdata        = '0;
      case (csr_reg)
         hca_pkg::REG_MIN_RADIUS: begin
            csr_prdata = hca_pkg::CSR_DATA_W'(min_radius_ff);
            if (csr_wr) begin
               min_radius_in = csr_pwdata[7:0];
            end
         end
         hca_pkg::REG_EDGE_VALUE: begin
            csr_prdata = hca_pkg::CSR_DATA_W'(edge_value_ff);
            if (csr_wr) begin
               edge_value_in = csr_pwdata[7:0];
            end
         end
         hca_pkg::REG_VOTE_THRESHOLD: begin
            csr_prdata = hca_pkg::CSR_DATA_W'(vote_threshold_ff);
            if (csr_wr) begin
               vote_threshold_in = csr_pwdata[2:0];
            end
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_radius_ff     <= hca_pkg::MIN_RADIUS_RST;
         edge_value_ff     <= hca_pkg::EDGE_VALUE_RST;
         vote_threshold_ff <= hca_pkg::VOTE_THRESHOLD_RST;
      end else begin
         min_radius_ff     <= min_radius_in;
         edge_value_ff     <= edge_value_in;
         vote_threshold_ff <= vote_threshold_in;
      end
   end

   hca_ctrl #(
      .IMAGE_ROWS (IMAGE_ROWS),
      .IMAGE_COLS (IMAGE_COLS),
      .NUM_RADII  (NUM_RADII)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .edge_value     (edge_value_ff),
      .vote_threshold (vote_threshold_ff),
      .op             (op),
      .op_k           (op_k),
      .retire_flags   (retire_flags),
      .retire_count   (retire_count),
      .epoch          (epoch),
      .wipe_we        (wipe_we),
      .wipe_addr      (wipe_addr)
   );

   hca_addr_gen #(
      .IMAGE_ROWS (IMAGE_ROWS),
      .IMAGE_COLS (IMAGE_COLS),
      .NUM_RADII  (NUM_RADII)
   ) u_addr_gen (
      .clock      (clock),
      .reset      (reset),
      .op         (op),
      .op_k       (op_k),
      .min_radius (min_radius_ff),
      .flags      (addr_flags),
      .addr       (addr)
   );

   hca_store #(
      .IMAGE_ROWS (IMAGE_ROWS),
      .IMAGE_COLS (IMAGE_COLS),
      .NUM_RADII  (NUM_RADII)
   ) u_store (
      .clock     (clock),
      .reset     (reset),
      .in_flags  (addr_flags),
      .in_addr   (addr),
      .epoch     (epoch),
      .wipe_we   (wipe_we),
      .wipe_addr (wipe_addr),
      .out_flags (retire_flags),
      .out_count (retire_count)
   );

   `HCA_ASSERT_IMPLY(a_wipe_blocks_requests, clock, reset, wipe_we, !req_tready, "request taken during a store wipe")
   `HCA_ASSERT_IMPLY(a_no_vote_during_wipe, clock, reset, op.valid || addr_flags.valid, !wipe_we, "vote issued during a store wipe")
   `HCA_ASSERT_IMPLY(a_idle_means_drained, clock, reset, retire_flags.valid || addr_flags.valid, !req_tready, "request taken with votes in flight")
   `HCA_ASSERT_NEXT(a_one_item_at_a_time, clock, reset, req_tvalid && req_tready, !req_tready, "second request taken straight after the first")

endmodule

FILE: src/hca_addr_gen.sv
`timescale 1ns / 1ps

module hca_addr_gen #(
   parameter int IMAGE_ROWS = hca_pkg::IMAGE_ROWS_DEF,
   parameter int IMAGE_COLS = hca_pkg::IMAGE_COLS_DEF,
   parameter int NUM_RADII  = hca_pkg::NUM_RADII_DEF,
   localparam longint unsigned CELLS =
      longint'(IMAGE_ROWS) * longint'(IMAGE_COLS) * longint'(NUM_RADII),
   localparam int K_W    = hca_pkg::idx_width(NUM_RADII),
   localparam int ADDR_W = hca_pkg::idx_width(CELLS)
) (
   input  logic                            clock,
   input  logic                            reset,
   input  hca_pkg::hca_op_type             op,
   input  logic [K_W-1:0]                  op_k,
   input  logic [hca_pkg::RADIUS_W-1:0]    min_radius,
   output hca_pkg::hca_flags_type          flags,
   output logic [ADDR_W-1:0]               addr
);

   localparam int RW    = hca_pkg::idx_width(IMAGE_ROWS);
   localparam int CW    = hca_pkg::idx_width(IMAGE_COLS);
   localparam int LIN_W = hca_pkg::idx_width(longint'(IMAGE_ROWS) * longint'(IMAGE_COLS));

   logic signed [hca_pkg::COORD_W-1:0] radius_s;
   logic signed [hca_pkg::COORD_W-1:0] row_s;
   logic signed [hca_pkg::COORD_W-1:0] col_s;
   logic signed [hca_pkg::COORD_W-1:0] cen_row;
   logic signed [hca_pkg::COORD_W-1:0] cen_col;
   logic                               hit;

   hca_pkg::hca_flags_type s1_flags_in, s1_flags_ff;
   hca_pkg::hca_flags_type s2_flags_ff, s3_flags_ff;
   logic [RW-1:0]     s1_row_in, s1_row_ff;
   logic [CW-1:0]     s1_col_in, s1_col_ff;
   logic [K_W-1:0]    s1_k_ff, s2_k_ff;
   logic [LIN_W-1:0]  s2_lin_in, s2_lin_ff;
   logic [ADDR_W-1:0] s3_addr_in, s3_addr_ff;

   always_comb begin
      row_s    = $signed(hca_pkg::COORD_W'(op.row));
      col_s    = $signed(hca_pkg::COORD_W'(op.col));
      radius_s = $signed(hca_pkg::COORD_W'(min_radius)) + $signed(hca_pkg::COORD_W'(op_k));
      if (op.query) begin
         radius_s = '0;
      end
      case (op.dir)
         hca_pkg::DIR_LEFT: begin
            cen_row = row_s;
            cen_col = col_s - radius_s;
         end
         hca_pkg::DIR_UP: begin
            cen_row = row_s - radius_s;
            cen_col = col_s;
         end
         hca_pkg::DIR_RIGHT: begin
            cen_row = row_s;
            cen_col = col_s + radius_s;
         end
         hca_pkg::DIR_DOWN: begin
            cen_row = row_s + radius_s;
            cen_col = col_s;
         end
         default: begin
            cen_row = row_s;
            cen_col = col_s;
         end
      endcase
      hit = op.k_ok
         && (cen_row >= 0) && (cen_row < $signed(hca_pkg::COORD_W'(IMAGE_ROWS)))
         && (cen_col >= 0) && (cen_col < $signed(hca_pkg::COORD_W'(IMAGE_COLS)));
      s1_flags_in.valid = op.valid;
      s1_flags_in.query = op.query;
      s1_flags_in.last  = op.last;
      s1_flags_in.hit   = hit;
      s1_row_in = hit ? RW'(cen_row) : '0;
      s1_col_in = hit ? CW'(cen_col) : '0;
      s2_lin_in = LIN_W'(s1_row_ff) * LIN_W'(IMAGE_COLS) + LIN_W'(s1_col_ff);
      s3_addr_in = ADDR_W'(s2_lin_ff) * ADDR_W'(NUM_RADII) + ADDR_W'(s2_k_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_flags_ff <= '0;
         s2_flags_ff <= '0;
         s3_flags_ff <= '0;
      end else begin
         s1_flags_ff <= s1_flags_in;
         s2_flags_ff <= s1_flags_ff;
         s3_flags_ff <= s2_flags_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_row_ff  <= s1_row_in;
      s1_col_ff  <= s1_col_in;
      s1_k_ff    <= op_k;
      s2_lin_ff  <= s2_lin_in;
      s2_k_ff    <= s1_k_ff;
      s3_addr_ff <= s3_addr_in;
   end

   assign flags = s3_flags_ff;
   assign addr  = s3_addr_ff;

endmodule

FILE: src/hca_store.sv
`timescale 1ns / 1ps

module hca_store #(
   parameter int IMAGE_ROWS = hca_pkg::IMAGE_ROWS_DEF,
   parameter int IMAGE_COLS = hca_pkg::IMAGE_COLS_DEF,
   parameter int NUM_RADII  = hca_pkg::NUM_RADII_DEF,
   localparam longint unsigned CELLS =
      longint'(IMAGE_ROWS) * longint'(IMAGE_COLS) * longint'(NUM_RADII),
   localparam int ADDR_W = hca_pkg::idx_width(CELLS)
) (
   input  logic                            clock,
   input  logic                            reset,
   input  hca_pkg::hca_flags_type          in_flags,
   input  logic [ADDR_W-1:0]               in_addr,
   input  logic [hca_pkg::EPOCH_W-1:0]     epoch,
   input  logic                            wipe_we,
   input  logic [ADDR_W-1:0]               wipe_addr,
   output hca_pkg::hca_flags_type          out_flags,
   output logic [hca_pkg::COUNT_W-1:0]     out_count
);

   localparam int WORD_W = hca_pkg::EPOCH_W + hca_pkg::COUNT_W;

   // Each word holds the epoch in which it was last written above its count;
   // a word from an older epoch reads as zero.
   logic [WORD_W-1:0] store_mem [0:CELLS-1];

   logic [WORD_W-1:0]            rdata_ff;
   hca_pkg::hca_flags_type       s4_flags_ff;
   logic [ADDR_W-1:0]            s4_addr_ff;
   logic                         fwd_valid_in, fwd_valid_ff;
   logic [ADDR_W-1:0]            fwd_addr_in, fwd_addr_ff;
   logic [WORD_W-1:0]            fwd_word_in, fwd_word_ff;
   logic [WORD_W-1:0]            old_word;
   logic [hca_pkg::COUNT_W-1:0]  old_count;
   logic [hca_pkg::COUNT_W-1:0]  new_count;
   logic                         vote_we;
   logic                         we;
   logic [ADDR_W-1:0]            wa;
   logic [WORD_W-1:0]            wd;

   always_comb begin
      old_word = (fwd_valid_ff && (fwd_addr_ff == s4_addr_ff)) ? fwd_word_ff : rdata_ff;
      old_count = (old_word[WORD_W-1:hca_pkg::COUNT_W] == epoch)
                  ? old_word[hca_pkg::COUNT_W-1:0] : '0;
      new_count = (old_count < hca_pkg::COUNT_MAX) ? old_count + 3'd1 : old_count;
      vote_we = s4_flags_ff.valid && s4_flags_ff.hit && !s4_flags_ff.query;
      we = vote_we || wipe_we;
      wa = wipe_we ? wipe_addr : s4_addr_ff;
      wd = wipe_we ? '0 : {epoch, new_count};
      fwd_valid_in = fwd_valid_ff || we;
      fwd_addr_in  = we ? wa : fwd_addr_ff;
      fwd_word_in  = we ? wd : fwd_word_ff;
   end

   always_ff @(posedge clock) begin
      if (we) begin
         store_mem[wa] <= wd;
      end
      rdata_ff <= store_mem[in_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_flags_ff  <= '0;
         fwd_valid_ff <= 1'b0;
      end else begin
         s4_flags_ff  <= in_flags;
         fwd_valid_ff <= fwd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s4_addr_ff  <= in_addr;
      fwd_addr_ff <= fwd_addr_in;
      fwd_word_ff <= fwd_word_in;
   end

   assign out_flags = s4_flags_ff;
   assign out_count = old_count;

endmodule

FILE: src/hca_ctrl.sv
`timescale 1ns / 1ps

module hca_ctrl #(
   parameter int IMAGE_ROWS = hca_pkg::IMAGE_ROWS_DEF,
   parameter int IMAGE_COLS = hca_pkg::IMAGE_COLS_DEF,
   parameter int NUM_RADII  = hca_pkg::NUM_RADII_DEF,
   localparam longint unsigned CELLS =
      longint'(IMAGE_ROWS) * longint'(IMAGE_COLS) * longint'(NUM_RADII),
   localparam int K_W    = hca_pkg::idx_width(NUM_RADII),
   localparam int ADDR_W = hca_pkg::idx_width(CELLS)
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [hca_pkg::REQ_W-1:0]       req_tdata,
   input  logic [hca_pkg::CMD_W-1:0]       req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [hca_pkg::RSP_W-1:0]       rsp_tdata,
   input  logic [hca_pkg::PIX_W-1:0]       edge_value,
   input  logic [hca_pkg::COUNT_W-1:0]     vote_threshold,
   output hca_pkg::hca_op_type             op,
   output logic [K_W-1:0]                  op_k,
   input  hca_pkg::hca_flags_type          retire_flags,
   input  logic [hca_pkg::COUNT_W-1:0]     retire_count,
   output logic [hca_pkg::EPOCH_W-1:0]     epoch,
   output logic                            wipe_we,
   output logic [ADDR_W-1:0]               wipe_addr
);

   localparam logic [K_W-1:0]    LAST_K    = K_W'(NUM_RADII - 1);
   localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELLS - 1);

   hca_pkg::hca_state_type state_in, state_ff;

   logic [hca_pkg::ROW_W-1:0]   in_row;
   logic [hca_pkg::COL_W-1:0]   in_col;
   logic [hca_pkg::RIDX_W-1:0]  in_ridx;
   logic [hca_pkg::PIX_W-1:0]   in_pix;
   logic                        req_fire;
   logic                        is_vote;
   logic                        is_query;
   logic                        is_clear;
   logic                        op_last;
   logic                        op_valid;
   logic                        wipe_end;
   logic                        rsp_load;

   logic [K_W-1:0]               k_in, k_ff;
   hca_pkg::hca_dir_type         dir_in, dir_ff;
   logic                         query_in, query_ff;
   logic                         k_ok_in, k_ok_ff;
   logic [hca_pkg::ROW_W-1:0]    row_in, row_ff;
   logic [hca_pkg::COL_W-1:0]    col_in, col_ff;
   logic [hca_pkg::EPOCH_W-1:0]  epoch_in, epoch_ff;
   logic [ADDR_W-1:0]            wipe_in, wipe_ff;
   logic [hca_pkg::COUNT_W-1:0]  count_in, count_ff;
   logic [hca_pkg::CAST_W-1:0]   cast_in, cast_ff;
   logic                         rsp_valid_in, rsp_valid_ff;
   logic [hca_pkg::RSP_W-1:0]    rsp_data_in, rsp_data_ff;

   assign in_row  = req_tdata[7:0];
   assign in_col  = req_tdata[16:8];
   assign in_ridx = req_tdata[22:17];
   assign in_pix  = req_tdata[30:23];

   assign req_fire = req_tvalid && req_tready;
   assign is_vote  = (req_tuser == hca_pkg::CMD_VOTE) && (in_pix == edge_value);
   assign is_query = (req_tuser == hca_pkg::CMD_QUERY);
   assign is_clear = (req_tuser == hca_pkg::CMD_CLEAR);
   assign op_last  = query_ff || ((k_ff == LAST_K) && (dir_ff == hca_pkg::DIR_DOWN));
   assign wipe_end = (wipe_ff == LAST_CELL);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         hca_pkg::ST_INIT: begin
            if (wipe_end) begin
               state_in = hca_pkg::ST_IDLE;
            end
         end
         hca_pkg::ST_IDLE: begin
            if (req_fire) begin
               if (is_vote || is_query) begin
                  state_in = hca_pkg::ST_ISSUE;
               end else if (is_clear && (epoch_ff == '1)) begin
                  state_in = hca_pkg::ST_WIPE;
               end else begin
                  state_in = hca_pkg::ST_FINISH;
               end
            end
         end
         hca_pkg::ST_ISSUE: begin
            if (op_last) begin
               state_in = hca_pkg::ST_DRAIN;
            end
         end
         hca_pkg::ST_DRAIN: begin
            if (retire_flags.valid && retire_flags.last) begin
               state_in = hca_pkg::ST_FINISH;
            end
         end
         hca_pkg::ST_WIPE: begin
            if (wipe_end) begin
               state_in = hca_pkg::ST_FINISH;
            end
         end
         hca_pkg::ST_FINISH: begin
            if (rsp_load) begin
               state_in = hca_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = hca_pkg::ST_INIT;
         end
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      wipe_we    = 1'b0;
      rsp_load   = 1'b0;
      op_valid   = 1'b0;
      case (state_ff)
         hca_pkg::ST_INIT: begin
            wipe_we = 1'b1;
         end
         hca_pkg::ST_IDLE: begin
            req_tready = 1'b1;
         end
         hca_pkg::ST_ISSUE: begin
            op_valid = 1'b1;
         end
         hca_pkg::ST_DRAIN: begin
            op_valid = 1'b0;
         end
         hca_pkg::ST_WIPE: begin
            wipe_we = 1'b1;
         end
         hca_pkg::ST_FINISH: begin
            rsp_load = !rsp_valid_ff || rsp_tready;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   always_comb begin
      op.valid = op_valid;
      op.query = query_ff;
      op.last  = op_last;
      op.k_ok  = k_ok_ff;
      op.dir   = dir_ff;
      op.row   = row_ff;
      op.col   = col_ff;
      op_k     = k_ff;

      k_in     = k_ff;
      dir_in   = dir_ff;
      query_in = query_ff;
      k_ok_in  = k_ok_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      epoch_in = epoch_ff;
      wipe_in  = wipe_ff;
      count_in = count_ff;
      cast_in  = cast_ff;

      if (req_fire) begin
         query_in = is_query;
         k_ok_in  = !is_query || (int'(in_ridx) < NUM_RADII);
         k_in     = is_query ? K_W'(in_ridx) : '0;
         dir_in   = hca_pkg::DIR_LEFT;
         row_in   = in_row;
         col_in   = in_col;
         count_in = '0;
         cast_in  = '0;
         if (is_clear) begin
            epoch_in = epoch_ff + 1'b1;
         end
      end else if (op_valid) begin
         dir_in = hca_pkg::hca_dir_type'(dir_ff + 2'd1);
         if (dir_ff == hca_pkg::DIR_DOWN) begin
            k_in = k_ff + 1'b1;
         end
      end

      if (retire_flags.valid) begin
         if (retire_flags.query) begin
            count_in = retire_flags.hit ? retire_count : '0;
         end else if (retire_flags.hit && (cast_ff != '1)) begin
            cast_in = cast_ff + 1'b1;
         end
      end

      if (wipe_we) begin
         wipe_in = wipe_end ? '0 : wipe_ff + 1'b1;
      end

      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = hca_pkg::RSP_W'({cast_ff, (count_ff > vote_threshold), count_ff});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= hca_pkg::ST_INIT;
         epoch_ff     <= '0;
         wipe_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         epoch_ff     <= epoch_in;
         wipe_ff      <= wipe_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff        <= k_in;
      dir_ff      <= dir_in;
      query_ff    <= query_in;
      k_ok_ff     <= k_ok_in;
      row_ff      <= row_in;
      col_ff      <= col_in;
      count_ff    <= count_in;
      cast_ff     <= cast_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign epoch      = epoch_ff;
   assign wipe_addr  = wipe_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

FILE: bench/tb_hough_circle_vote_accumulator.sv
`timescale 1ns / 1ps

module tb_hough_circle_vote_accumulator;

   localparam int ROWS  = hca_pkg::IMAGE_ROWS_DEF;
   localparam int COLS  = hca_pkg::IMAGE_COLS_DEF;
   localparam int RADII = hca_pkg::NUM_RADII_DEF;
   localparam int unsigned STALL_LIMIT = 3 * ROWS * COLS * RADII + 200000;
   localparam int MAX_CLEARS = 12;
   localparam int PHASE_WORDS = 187;
   localparam logic [hca_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

   typedef struct packed {
      logic [hca_pkg::COUNT_W-1:0] vote_count;
      logic                        is_circle;
      logic [hca_pkg::CAST_W-1:0]  votes_cast;
   } tally_fields_type;

   logic                           clock;
   logic                           reset;
   logic                           req_tvalid;
   logic                           req_tready;
   logic [hca_pkg::REQ_W-1:0]      req_tdata;
   logic [hca_pkg::CMD_W-1:0]      req_tuser;
   logic                           rsp_tvalid;
   logic                           rsp_tready;
   logic [hca_pkg::RSP_W-1:0]      rsp_tdata;
   logic                           csr_psel;
   logic                           csr_penable;
   logic                           csr_pwrite;
   logic [hca_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [hca_pkg::CSR_DATA_W-1:0] csr_pwdata;
   logic [hca_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                           csr_pready;

   // Sparse copy of the counter store: a missing key is a zero counter.
   logic [hca_pkg::COUNT_W-1:0] vote_cells[int];
   int cfg_min_radius;
   int cfg_edge_value;
   int cfg_threshold;

   tally_fields_type pending_tally[$];

   bit steady;
   int mismatches;
   int words_sent;
   int words_checked;
   int edge_votes;
   int queries_sent;
   int circles_expected;
   int clears_sent;
   int other_words;
   int settings_applied;
   int unsigned idle_cycles;
   int last_row;
   int last_col;
   int last_k;

   hough_circle_vote_accumulator u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic void flag_mismatch(string what, int want, int got);
      mismatches++;
      if (mismatches <= 10) begin
         $display("Mismatch on %s at %0t: expected %0d, got %0d", what, $time, want, got);
      end
   endfunction

   function automatic int pick_gap();
      int p;
      if (steady) begin
         return 0;
      end
      p = $urandom_range(0, 99);
      if (p < 55) begin
         return 0;
      end
      if (p < 88) begin
         return $urandom_range(1, 3);
      end
      if (p < 97) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(20, 60);
   endfunction

   function automatic int cell_key(int row, int col, int k);
      return (row * COLS + col) * RADII + k;
   endfunction

   function automatic int bump_cell(int row, int col, int k);
      int key;
      if (row < 0 || row >= ROWS || col < 0 || col >= COLS) begin
         return 0;
      end
      key = cell_key(row, col, k);
      if (!vote_cells.exists(key)) begin
         vote_cells[key] = '0;
      end
      if (vote_cells[key] < hca_pkg::COUNT_MAX) begin
         vote_cells[key] = vote_cells[key] + 1'b1;
      end
      return 1;
   endfunction

   function automatic tally_fields_type tally_word(logic [hca_pkg::CMD_W-1:0] cmd, int row,
                                                   int col, int ridx, int pix);
      tally_fields_type res;
      int cast;
      int r;
      int cnt;
      res = '0;
      cast = 0;
      if (cmd == hca_pkg::CMD_VOTE) begin
         if (pix == cfg_edge_value) begin
            for (int k = 0; k < RADII; k++) begin
               r = cfg_min_radius + k;
               cast += bump_cell(row, col - r, k);
               cast += bump_cell(row - r, col, k);
               cast += bump_cell(row, col + r, k);
               cast += bump_cell(row + r, col, k);
            end
            if (cast > 255) begin
               cast = 255;
            end
         end
         res.votes_cast = cast[hca_pkg::CAST_W-1:0];
      end else if (cmd == hca_pkg::CMD_QUERY) begin
         if (row < ROWS && col < COLS && ridx < RADII) begin
            cnt = 0;
            if (vote_cells.exists(cell_key(row, col, ridx))) begin
               cnt = vote_cells[cell_key(row, col, ridx)];
            end
            res.vote_count = cnt[hca_pkg::COUNT_W-1:0];
            res.is_circle = (cnt > cfg_threshold);
         end
      end else if (cmd == hca_pkg::CMD_CLEAR) begin
         vote_cells.delete();
      end
      return res;
   endfunction

   // Offers one request word, records its expected response once it is taken and then
   // leaves a random gap. The valid stays high when no gap follows.
   task automatic send_word(logic [hca_pkg::CMD_W-1:0] cmd, int row, int col, int ridx,
                            int pix);
      tally_fields_type want;
      int gap;
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= {1'b0, 8'(pix), 6'(ridx), 9'(col), 8'(row)};
      do begin
         @(posedge clock);
      end while (!req_tready);
      want = tally_word(cmd, row, col, ridx, pix);
      pending_tally.push_back(want);
      words_sent++;
      if (cmd == hca_pkg::CMD_VOTE && pix == cfg_edge_value) begin
         edge_votes++;
      end else if (cmd == hca_pkg::CMD_QUERY) begin
         queries_sent++;
         circles_expected += want.is_circle;
      end else if (cmd == hca_pkg::CMD_CLEAR) begin
         clears_sent++;
      end else begin
         other_words++;
      end
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      do begin
         @(posedge clock);
      end while (pending_tally.size() != 0);
   endtask

   task automatic csr_access(hca_pkg::hca_reg_type which, logic write, int value,
                             output int rdata);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= write;
      csr_paddr <= {which, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do begin
         @(posedge clock);
      end while (!csr_pready);
      rdata = csr_prdata;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic check_register(hca_pkg::hca_reg_type which, int want);
      int rdata;
      int mask;
      csr_access(which, 1'b0, 0, rdata);
      mask = (which == hca_pkg::REG_VOTE_THRESHOLD) ? 32'h7 : 32'hFF;
      if ((rdata & mask) != want) begin
         flag_mismatch(which.name(), want, rdata & mask);
      end
   endtask

   task automatic set_register(hca_pkg::hca_reg_type which, int value);
      int rdata;
      csr_access(which, 1'b1, value, rdata);
      case (which)
         hca_pkg::REG_MIN_RADIUS: begin
            cfg_min_radius = value & 8'hFF;
         end
         hca_pkg::REG_EDGE_VALUE: begin
            cfg_edge_value = value & 8'hFF;
         end
         default: begin
            cfg_threshold = value & 3'h7;
         end
      endcase
      settings_applied++;
      check_register(which,
                     (which == hca_pkg::REG_VOTE_THRESHOLD) ? (value & 7) : (value & 8'hFF));
   endtask

   task automatic send_noise();
      int p;
      int pix;
      p = $urandom_range(0, 99);
      pix = ($urandom_range(0, 1) == 1) ? cfg_edge_value : $urandom_range(0, 255);
      if (p < 40) begin
         send_word(hca_pkg::CMD_VOTE, $urandom_range(0, 255), $urandom_range(0, 511),
                   $urandom_range(0, 63), pix);
      end else if (p < 60) begin
         send_word(hca_pkg::CMD_QUERY, $urandom_range(0, 255), $urandom_range(0, 511),
                   $urandom_range(0, 63), pix);
      end else if (p < 85) begin
         send_word(hca_pkg::CMD_QUERY, last_row, last_col, $urandom_range(0, RADII - 1), pix);
      end else begin
         send_word(CMD_UNUSED, $urandom_range(0, 255), $urandom_range(0, 511),
                   $urandom_range(0, 63), $urandom_range(0, 255));
      end
   endtask

   // Sends some of the edge pixels that sit on the sides of one centre and vote for it at one radius, then
   // queries that centre. Centres are often reused so that counters climb to saturation.
   task automatic run_circle();
      int r;
      int n;
      int d;
      int start;
      int pr[4];
      int pc[4];
      if ($urandom_range(0, 99) >= 40) begin
         last_row = $urandom_range(0, ROWS - 1);
         last_col = $urandom_range(0, COLS - 1);
         last_k = $urandom_range(0, RADII - 1);
      end
      r = cfg_min_radius + last_k;
      pr = '{last_row, last_row + r, last_row, last_row - r};
      pc = '{last_col + r, last_col, last_col - r, last_col};
      n = $urandom_range(1, 4);
      start = $urandom_range(0, 3);
      for (int i = 0; i < 4 && n > 0; i++) begin
         d = (start + i) % 4;
         if (pr[d] >= 0 && pr[d] <= 255 && pc[d] >= 0 && pc[d] <= 511) begin
            send_word(hca_pkg::CMD_VOTE, pr[d], pc[d], $urandom_range(0, 63), cfg_edge_value);
            n--;
            if ($urandom_range(0, 99) < 15) begin
               send_noise();
            end
         end
      end
      send_word(hca_pkg::CMD_QUERY, last_row, last_col, last_k, $urandom_range(0, 255));
      if ($urandom_range(0, 99) < 30) begin
         send_word(hca_pkg::CMD_QUERY, last_row, last_col, $urandom_range(0, RADII - 1),
                   $urandom_range(0, 255));
      end
   endtask

   task automatic test_register_reset();
      check_register(hca_pkg::REG_MIN_RADIUS, hca_pkg::MIN_RADIUS_RST);
      check_register(hca_pkg::REG_EDGE_VALUE, hca_pkg::EDGE_VALUE_RST);
      check_register(hca_pkg::REG_VOTE_THRESHOLD, hca_pkg::VOTE_THRESHOLD_RST);
   endtask

   task automatic test_corner_words();
      send_word(hca_pkg::CMD_CLEAR, 0, 0, 0, 0);
      send_word(hca_pkg::CMD_QUERY, 0, 0, 0, 0);
      send_word(hca_pkg::CMD_VOTE, 0, 0, 0, 255);
      send_word(hca_pkg::CMD_QUERY, 0, 10, 0, 0);
      send_word(hca_pkg::CMD_VOTE, ROWS - 1, COLS - 1, 63, 255);
      send_word(hca_pkg::CMD_VOTE, 255, 511, 63, 255);
      send_word(hca_pkg::CMD_VOTE, 100, 100, 0, 254);
      send_word(hca_pkg::CMD_VOTE, 100, 100, 0, 0);
      send_word(CMD_UNUSED, 255, 511, 63, 255);
      repeat (5) send_word(hca_pkg::CMD_VOTE, 50, 60, 21, 255);
      send_word(hca_pkg::CMD_QUERY, 50, 50, 0, 0);
      send_word(hca_pkg::CMD_QUERY, 50, 1, RADII - 1, 0);
      send_word(hca_pkg::CMD_QUERY, ROWS, 0, 0, 0);
      send_word(hca_pkg::CMD_QUERY, 255, 50, 0, 0);
      send_word(hca_pkg::CMD_QUERY, 50, COLS, 0, 0);
      send_word(hca_pkg::CMD_QUERY, 50, 511, 0, 0);
      send_word(hca_pkg::CMD_QUERY, 50, 50, RADII, 0);
      send_word(hca_pkg::CMD_QUERY, 50, 50, 63, 0);
      send_word(hca_pkg::CMD_CLEAR, 255, 511, 63, 255);
      send_word(hca_pkg::CMD_QUERY, 50, 50, 0, 0);
      wait_idle();
   endtask

   task automatic test_zero_radius();
      set_register(hca_pkg::REG_MIN_RADIUS, 0);
      set_register(hca_pkg::REG_EDGE_VALUE, 0);
      set_register(hca_pkg::REG_VOTE_THRESHOLD, 0);
      send_word(hca_pkg::CMD_VOTE, 120, 160, 0, 0);
      send_word(hca_pkg::CMD_QUERY, 120, 160, 0, 0);
      send_word(hca_pkg::CMD_QUERY, 120, 161, 1, 0);
      send_word(hca_pkg::CMD_VOTE, 0, 0, 0, 0);
      send_word(hca_pkg::CMD_QUERY, 0, 0, 0, 0);
      wait_idle();
   endtask

   task automatic test_random_phases();
      int radius_set[6] = '{1, 255, 0, 37, 10, -1};
      int edge_set[6] = '{0, 128, 77, 200, 255, -1};
      int thresh_set[6] = '{0, 4, 7, 2, 3, -1};
      int target;
      int p;
      for (int ph = 0; ph < 6; ph++) begin
         set_register(hca_pkg::REG_MIN_RADIUS,
                      (radius_set[ph] < 0) ? $urandom_range(0, 255) : radius_set[ph]);
         set_register(hca_pkg::REG_EDGE_VALUE,
                      (edge_set[ph] < 0) ? $urandom_range(0, 255) : edge_set[ph]);
         set_register(hca_pkg::REG_VOTE_THRESHOLD,
                      (thresh_set[ph] < 0) ? $urandom_range(0, 7) : thresh_set[ph]);
         target = words_sent + PHASE_WORDS;
         while (words_sent < target) begin
            if ($urandom_range(0, 39) == 0) begin
               steady = !steady;
            end
            p = $urandom_range(0, 99);
            if (p < 60) begin
               run_circle();
            end else if (p < 97 || clears_sent >= MAX_CLEARS) begin
               send_noise();
            end else begin
               send_word(hca_pkg::CMD_CLEAR, $urandom_range(0, 255), $urandom_range(0, 511),
                         $urandom_range(0, 63), $urandom_range(0, 255));
            end
         end
         steady = 1'b0;
         wait_idle();
      end
   endtask

   initial begin
      int hold;
      logic ready_next;
      hold = 0;
      ready_next = 1'b0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold > 0) begin
            hold--;
         end else if (steady || $urandom_range(0, 99) < 65) begin
            ready_next = 1'b1;
            hold = $urandom_range(1, 8);
         end else begin
            ready_next = 1'b0;
            hold = pick_gap();
         end
         rsp_tready <= ready_next;
      end
   end

   always @(posedge clock) begin
      tally_fields_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         words_checked++;
         if (pending_tally.size() == 0) begin
            flag_mismatch("unexpected response word", 0, rsp_tdata);
         end else begin
            want = pending_tally.pop_front();
            if (rsp_tdata[2:0] !== want.vote_count) begin
               flag_mismatch("vote_count", want.vote_count, rsp_tdata[2:0]);
            end
            if (rsp_tdata[3] !== want.is_circle) begin
               flag_mismatch("is_circle", want.is_circle, rsp_tdata[3]);
            end
            if (rsp_tdata[11:4] !== want.votes_cast) begin
               flag_mismatch("votes_cast", want.votes_cast, rsp_tdata[11:4]);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("Timed out after %0d cycles without a handshake.", idle_cycles);
         $display("** hough_circle_vote_accumulator: FAILED **");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      steady = 1'b0;
      cfg_min_radius = hca_pkg::MIN_RADIUS_RST;
      cfg_edge_value = hca_pkg::EDGE_VALUE_RST;
      cfg_threshold = hca_pkg::VOTE_THRESHOLD_RST;
      last_row = 0;
      last_col = 0;
      last_k = 0;
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tuser <= hca_pkg::CMD_VOTE;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_register_reset();
      test_corner_words();
      test_zero_radius();
      test_random_phases();
      repeat (300) @(posedge clock);
      $display("Sent %0d words: %0d edge pixels, %0d queries (%0d circles), %0d clears, %0d others.",
               words_sent, edge_votes, queries_sent, circles_expected, clears_sent, other_words);
      $display("Applied %0d register settings and checked %0d response words.",
               settings_applied, words_checked);
      if (mismatches == 0 && pending_tally.size() == 0) begin
         $display("** hough_circle_vote_accumulator: PASSED **");
      end else begin
         $display("** hough_circle_vote_accumulator: FAILED **");
      end
      $finish;
   end

endmodule
